// ===== sv/pds_pkg.sv =====
// shared types and constants for the pairwise distance statistics block
package pds_pkg;

  localparam int MaxPointsDefault = 64;
  localparam int DistW = 17;
  localparam int SumW = 28;
  localparam int CountW = 11;
  localparam int IdxW = 6;
  localparam logic [DistW-1:0] ThreshReset = 17'd160;
  localparam logic [DistW-1:0] DistAllOnes = '1;

  typedef enum logic {
    KIND_PAIR = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic set_end;
  } point_in_t;

  typedef struct packed {
    logic kind;
    logic [IdxW-1:0] first_index;
    logic [IdxW-1:0] second_index;
    logic [DistW-1:0] distance;
    logic [DistW-1:0] min_distance;
    logic [DistW-1:0] max_distance;
    logic [DistW-1:0] mean_distance;
    logic [CountW-1:0] pair_count;
    logic dropped;
    logic last_result;
  } result_t;

endpackage

// ===== sv/pairwise_distance_statistics_core.sv =====
// top level: point store, pair sequencer, shared square root and mean divider
// per stored point compared: read, wait, two squares on the shared multiplier, sum,
//   17-step square root, accumulate; a close pair leaves once the next is found or the pass ends
// a new point is taken only once the last is done; set_end adds the 28-step divide, none with no pairs
// busy is high for the whole of an item; results appear one per strobe, never stalled
// reset (rst, synchronous): clears the set, the threshold returns to 160
module pairwise_distance_statistics_core #(
  parameter int MaxPoints = pds_pkg::MaxPointsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  pds_pkg::point_in_t    in_item,
  output logic                  busy,
  input  logic                  cfg_we,
  input  logic [pds_pkg::DistW-1:0] cfg_data,
  output logic                  result_valid,
  output pds_pkg::result_t      result
);

  localparam int AddrW = 6;
  localparam int CntW = 7;
  localparam logic [CntW-1:0] Cap = CntW'(MaxPoints);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_WAIT, S_SQ, S_SUM, S_ROOT, S_ACC, S_STORE, S_DIV, S_SUMMARY
  } state_t;

  state_t state;
  logic [pds_pkg::DistW-1:0] threshold;
  logic [CntW-1:0] point_count;
  logic [pds_pkg::DistW-1:0] running_min, running_max;
  logic [pds_pkg::SumW-1:0] distance_sum;
  logic [pds_pkg::CountW-1:0] pairs_seen;
  logic overflow_seen;
  logic signed [15:0] cur_x, cur_y;
  logic cur_end;
  logic [CntW-1:0] idx;
  logic signed [16:0] dx, dy;
  logic [33:0] sq_x, sq_y, sq_sum;
  logic sq_start, sq_done;
  logic [16:0] root;
  logic div_start, div_done;
  logic [27:0] quotient;
  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [31:0] ram_rd;
  logic sq_phase;
  logic pend_valid;
  logic [AddrW-1:0] pend_first;
  logic [pds_pkg::DistW-1:0] pend_dist;

  // one ram port: write the new point at store time, else read index
  assign ram_we = (state == S_STORE) && (point_count < Cap);
  assign ram_addr = (state == S_STORE) ? point_count[AddrW-1:0] : idx[AddrW-1:0];
  assign busy = (state != S_IDLE);
  assign sq_start = (state == S_SUM);
  assign div_start = (state == S_STORE) && cur_end && (pairs_seen != '0);

  pds_ram #(.Width(32), .Depth(64)) u_store (
    .clk(clk), .wr_en(ram_we), .addr(ram_addr),
    .wr_data({cur_y, cur_x}), .rd_data(ram_rd)
  );

  pds_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_sum),
    .done(sq_done), .root(root)
  );

  pds_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(distance_sum),
    .divisor(pairs_seen), .done(div_done), .quotient(quotient)
  );

  // sequencer, statistics and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      threshold <= pds_pkg::ThreshReset;
      point_count <= '0;
      running_min <= pds_pkg::DistAllOnes;
      running_max <= '0;
      distance_sum <= '0;
      pairs_seen <= '0;
      overflow_seen <= 1'b0;
      result_valid <= 1'b0;
      idx <= '0;
      sq_phase <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        threshold <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur_x <= in_item.point_x;
            cur_y <= in_item.point_y;
            cur_end <= in_item.set_end;
            idx <= '0;
            pend_valid <= 1'b0;
            if (point_count >= Cap) begin
              overflow_seen <= 1'b1;
              state <= S_STORE;
            end else if (point_count == '0) begin
              state <= S_STORE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_WAIT;
        S_WAIT: begin
          dx <= 17'(cur_x) - 17'(signed'(ram_rd[15:0]));
          dy <= 17'(cur_y) - 17'(signed'(ram_rd[31:16]));
          sq_phase <= 1'b0;
          state <= S_SQ;
        end
        S_SQ: begin
          // shared multiplier squares dx then dy
          if (!sq_phase) begin
            sq_x <= 34'(dx * dx);
            sq_phase <= 1'b1;
          end else begin
            sq_y <= 34'(dy * dy);
            state <= S_SUM;
          end
        end
        S_SUM: state <= S_ROOT;
        S_ROOT: begin
          if (sq_done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (root < running_min) running_min <= root;
          if (root > running_max) running_max <= root;
          distance_sum <= distance_sum + 28'(root);
          pairs_seen <= pairs_seen + 11'd1;
          // a close pair is held back until it is known whether another follows
          if (root < threshold) begin
            if (pend_valid) begin
              result_valid <= 1'b1;
              result <= '{kind: pds_pkg::KIND_PAIR, first_index: pend_first,
                          second_index: point_count[AddrW-1:0], distance: pend_dist,
                          last_result: 1'b0, default: '0};
            end
            pend_valid <= 1'b1;
            pend_first <= idx[AddrW-1:0];
            pend_dist <= root;
          end
          idx <= idx + 7'd1;
          state <= ((idx + 7'd1) == point_count) ? S_STORE : S_READ;
        end
        S_STORE: begin
          // flush the held close pair, last unless a summary follows
          if (pend_valid) begin
            result_valid <= 1'b1;
            result <= '{kind: pds_pkg::KIND_PAIR, first_index: pend_first,
                        second_index: point_count[AddrW-1:0], distance: pend_dist,
                        last_result: !cur_end, default: '0};
            pend_valid <= 1'b0;
          end
          if (point_count < Cap) begin
            point_count <= point_count + 7'd1;
          end
          if (!cur_end) state <= S_IDLE;
          else if (pairs_seen != '0) state <= S_DIV;
          else state <= S_SUMMARY;
        end
        S_DIV: begin
          if (div_done) state <= S_SUMMARY;
        end
        S_SUMMARY: begin
          result_valid <= 1'b1;
          result <= '{kind: pds_pkg::KIND_SUMMARY,
                      min_distance: (pairs_seen != '0) ? running_min : pds_pkg::DistAllOnes,
                      max_distance: (pairs_seen != '0) ? running_max : '0,
                      mean_distance: (pairs_seen != '0) ? quotient[16:0] : '0,
                      pair_count: pairs_seen, dropped: overflow_seen,
                      last_result: 1'b1, default: '0};
          point_count <= '0;
          running_min <= pds_pkg::DistAllOnes;
          running_max <= '0;
          distance_sum <= '0;
          pairs_seen <= '0;
          overflow_seen <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sq_sum = sq_x + sq_y;

endmodule

// ===== sv/pds_ram.sv =====
// generic single-port ram with registered read
module pds_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wr_data,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

endmodule

// ===== sv/pds_sqrt.sv =====
// bit-serial integer square root, one result bit per cycle
module pds_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] radicand,
  output logic        done,
  output logic [16:0] root
);

  logic [33:0] rem;
  logic [33:0] rad;
  logic [16:0] res;
  logic [4:0]  cnt;
  logic        active;
  logic [18:0] trial;
  logic [18:0] rem_top;

  // shift in two radicand bits, try subtracting 4*res+1
  always_comb begin
    rem_top = {rem[16:0], rad[33:32]};
    trial = {res, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt <= 5'd16;
        rem <= '0;
        res <= '0;
        rad <= radicand;
      end else if (active) begin
        rad <= {rad[31:0], 2'b00};
        if (rem_top >= trial) begin
          rem <= {15'd0, rem_top - trial};
          res <= {res[15:0], 1'b1};
        end else begin
          rem <= {15'd0, rem_top};
          res <= {res[15:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          active <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign root = res;

endmodule

// ===== sv/pds_div.sv =====
// restoring divider for the mean, one quotient bit per cycle
module pds_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [27:0] dividend,
  input  logic [10:0] divisor,
  output logic        done,
  output logic [27:0] quotient
);

  logic [27:0] quo;
  logic [11:0] rem;
  logic [4:0]  cnt;
  logic        active;
  logic [11:0] shifted;

  assign shifted = {rem[10:0], quo[27]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt <= 5'd27;
        quo <= dividend;
        rem <= '0;
      end else if (active) begin
        if (shifted >= {1'b0, divisor}) begin
          rem <= shifted - {1'b0, divisor};
          quo <= {quo[26:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[26:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          active <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== sv/pds_checker.sv =====
// port-level checks for the core, bound to the top level
module pds_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input pds_pkg::result_t result
);

  // an accepted item makes the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // a summary is always the last result of its item
  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind |-> result.last_result)
    else $error("summary not marked last");

  // the summary ends the item: busy is already low while it is shown
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind |-> !busy) else $error("busy during summary");

  // a pair never pairs a point with itself
  a_pair_idx: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.kind |-> result.first_index < result.second_index)
    else $error("bad pair index");

endmodule

bind pairwise_distance_statistics_core pds_checker u_pds_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .result_valid(result_valid), .result(result)
);

// ===== dv/tb.sv =====
// self-checking testbench for the pairwise distance statistics core
module tb;

  localparam int MaxPts = 64;
  localparam int WatchdogLimit = 20000;

  // expected results and the predictor state for one point set
  class distance_scoreboard;
    logic [31:0] stored_xy[MaxPts];
    int unsigned stored_n;
    logic [pds_pkg::DistW-1:0] min_d, max_d, thresh;
    logic [pds_pkg::SumW-1:0] sum_d;
    logic [pds_pkg::CountW-1:0] pair_n;
    bit overflow;
    pds_pkg::result_t expected_q[$];
    int unsigned errors, checked, summaries, close_pairs;

    function void clear_set();
      stored_n = 0;
      min_d = pds_pkg::DistAllOnes;
      max_d = '0;
      sum_d = '0;
      pair_n = '0;
      overflow = 0;
    endfunction

    function void set_threshold(logic [pds_pkg::DistW-1:0] t);
      thresh = t;
    endfunction

    function void queue_expected(pds_pkg::result_t r);
      expected_q = {expected_q, r};
    endfunction

    function logic [pds_pkg::DistW-1:0] int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root[pds_pkg::DistW-1:0];
    endfunction

    // note an accepted point and queue what it produces
    function void note_point(pds_pkg::point_in_t p);
      longint dx, dy;
      logic signed [15:0] ox, oy;
      logic [pds_pkg::DistW-1:0] d;
      pds_pkg::result_t r;
      int first_new;
      first_new = expected_q.size();
      if (stored_n < MaxPts) begin
        for (int i = 0; i < stored_n; i++) begin
          ox = stored_xy[i][15:0];
          oy = stored_xy[i][31:16];
          dx = longint'(p.point_x) - longint'(ox);
          dy = longint'(p.point_y) - longint'(oy);
          d = int_sqrt(longint'(dx * dx + dy * dy));
          if (d < min_d) min_d = d;
          if (d > max_d) max_d = d;
          sum_d = sum_d + pds_pkg::SumW'(d);
          pair_n = pair_n + pds_pkg::CountW'(1);
          if (d < thresh) begin
            r = '0;
            r.kind = pds_pkg::KIND_PAIR;
            r.first_index = i[pds_pkg::IdxW-1:0];
            r.second_index = stored_n[pds_pkg::IdxW-1:0];
            r.distance = d;
            queue_expected(r);
          end
        end
        stored_xy[stored_n] = {p.point_y, p.point_x};
        stored_n++;
      end else begin
        overflow = 1;
      end
      if (p.set_end) begin
        r = '0;
        r.kind = pds_pkg::KIND_SUMMARY;
        r.min_distance = (pair_n != 0) ? min_d : pds_pkg::DistAllOnes;
        r.max_distance = (pair_n != 0) ? max_d : '0;
        r.mean_distance = (pair_n != 0) ? pds_pkg::DistW'(sum_d / pair_n) : '0;
        r.pair_count = pair_n;
        r.dropped = overflow;
        queue_expected(r);
        clear_set();
      end
      if (expected_q.size() > first_new) expected_q[expected_q.size()-1].last_result = 1;
    endfunction

    function void report_mismatch(string what, pds_pkg::result_t exp_r,
                                  pds_pkg::result_t act_r);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %p got %p", what, exp_r, act_r);
    endfunction

    // compare one result against the oldest expectation, field by field
    function void check_result(pds_pkg::result_t act_r);
      pds_pkg::result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", '0, act_r);
        return;
      end
      e = expected_q.pop_front();
      if (act_r.kind == pds_pkg::KIND_SUMMARY) summaries++; else close_pairs++;
      if (act_r.kind !== e.kind) report_mismatch("kind", e, act_r);
      else if (act_r.first_index !== e.first_index) report_mismatch("first_index", e, act_r);
      else if (act_r.second_index !== e.second_index) report_mismatch("second_index", e, act_r);
      else if (act_r.distance !== e.distance) report_mismatch("distance", e, act_r);
      else if (act_r.min_distance !== e.min_distance) report_mismatch("min_distance", e, act_r);
      else if (act_r.max_distance !== e.max_distance) report_mismatch("max_distance", e, act_r);
      else if (act_r.mean_distance !== e.mean_distance)
        report_mismatch("mean_distance", e, act_r);
      else if (act_r.pair_count !== e.pair_count) report_mismatch("pair_count", e, act_r);
      else if (act_r.dropped !== e.dropped) report_mismatch("dropped", e, act_r);
      else if (act_r.last_result !== e.last_result) report_mismatch("last_result", e, act_r);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  pds_pkg::point_in_t in_item = '0;
  logic busy;
  logic cfg_we = 0;
  logic [pds_pkg::DistW-1:0] cfg_data = '0;
  logic result_valid;
  pds_pkg::result_t result;

  distance_scoreboard sb;
  int unsigned idle_pct;
  int unsigned points_sent;
  int unsigned idle_cycles;
  bit timed_out;

  pairwise_distance_statistics_core i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .in_item(in_item),
    .busy(busy),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .result(result)
  );

  // clock
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (result_valid) sb.check_result(result);
      if (result_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
        $display("watchdog expired, %0d results outstanding", sb.expected_q.size());
        $display("[pairwise_distance_statistics_core] ERROR");
        $finish;
      end
    end
  end

  // present one point and hold it until accepted; start stays high for a following point
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
    pds_pkg::point_in_t p;
    p.point_x = x;
    p.point_y = y;
    p.set_end = last;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_item <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_point(p);
    points_sent++;
  endtask

  // write the threshold once the block has drained
  task automatic write_threshold(logic [pds_pkg::DistW-1:0] t);
    start <= 0;
    while (sb.expected_q.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= t;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_threshold(t);
  endtask

  function automatic logic signed [15:0] rand_coord(int unsigned spread);
    case ($urandom_range(3))
      0: return 16'($urandom);
      default: return 16'($signed($urandom_range(2 * spread)) - $signed(spread));
    endcase
  endfunction

  // random sets: mostly small clustered ones
  task automatic random_sets(int unsigned n_points, int unsigned spread);
    int unsigned left, set_len;
    left = n_points;
    while (left > 0) begin
      set_len = $urandom_range(1, 8);
      if (set_len > left) set_len = left;
      for (int k = 0; k < set_len; k++)
        send_point(rand_coord(spread), rand_coord(spread), k == set_len - 1);
      left -= set_len;
    end
  endtask

  initial begin
    sb = new();
    sb.clear_set();
    sb.set_threshold(pds_pkg::ThreshReset);
    idle_pct = 0;
    points_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: lone point summary, extremes, coincident points
    send_point(16'sh0000, 16'sh0000, 1);
    send_point(-16'sd32768, -16'sd32768, 0);
    send_point(16'sd32767, 16'sd32767, 0);
    send_point(16'sd32767, -16'sd32768, 0);
    send_point(16'sd32767, 16'sd32767, 1);
    send_point(16'sd5, 16'sd3, 0);
    send_point(16'sd5, 16'sd3, 0);
    send_point(-16'sd100, 16'sd60, 1);

    // directed: fill the store and overflow, with the summary on a dropped point
    write_threshold(17'd0);
    for (int k = 0; k < MaxPts + 2; k++)
      send_point(16'($urandom), 16'($urandom), k == MaxPts + 1);

    write_threshold(17'h1FFFF);
    send_point(16'sh5555, 16'shAAAA, 0);
    send_point(16'shAAAA, 16'sh5555, 0);
    send_point(16'sh1234, -16'sd1, 1);

    // random phases across thresholds and idling
    write_threshold(pds_pkg::ThreshReset);
    idle_pct = 0;
    random_sets(20, 200);
    idle_pct = 72;
    random_sets(20, 300);
    write_threshold(17'($urandom_range(17'h1FFFF)));
    idle_pct = 27;
    random_sets(15, 2000);
    write_threshold(17'd1000);
    idle_pct = 0;
    random_sets(15, 500);

    start <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("run covered %0d points, %0d close pairs, %0d summaries",
             points_sent, sb.close_pairs, sb.summaries);
    $display("thresholds 0, max, reset and random; store overflow; %0d mismatches",
             sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[pairwise_distance_statistics_core] OK");
    end else begin
      $display("[pairwise_distance_statistics_core] ERROR");
    end
    $finish;
  end
endmodule

// ===== pairwise_distance_statistics_core.f =====
sv/pds_pkg.sv
sv/pds_ram.sv
sv/pds_sqrt.sv
sv/pds_div.sv
sv/pairwise_distance_statistics_core.sv
sv/pds_checker.sv
dv/tb.sv
